@@ design/fer_pkg.sv @@
// Shared constants and types for the following-error RMS monitor.
// Holds the window geometry, datapath widths and the command and status structs.
// Depends on nothing.
package fer_pkg;

    localparam int WINDOW     = 1000;
    localparam int WARN_LIMIT = 10000;

    localparam int SAMPLE_W = 24;
    localparam int BASE_W   = 23;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int POS_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = SQ_W + CNT_W;
    localparam int RAD_W    = SQ_W + (SQ_W % 2);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int WCNT_W   = 14;
    localparam int STEP_W   = $clog2(SQ_W + 1);
    localparam int MDATA_W  = ((2 * SAMPLE_W + 1 + 7) / 8) * 8;

    localparam logic [BASE_W-1:0]   BASE_MIN   = BASE_W'(7);
    localparam logic [WCNT_W-1:0]   COUNT_MAX  = {WCNT_W{1'b1}};
    localparam logic [WCNT_W-1:0]   WARN_LIM   = WCNT_W'(WARN_LIMIT);
    localparam logic [POS_W-1:0]    POS_LAST   = POS_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]    COUNT_FULL = CNT_W'(WINDOW);
    localparam logic [STEP_W-1:0]   DIV_STEPS  = STEP_W'(SQ_W - 1);
    localparam logic [STEP_W-1:0]   ROOT_STEPS = STEP_W'(ROOT_W - 1);

    typedef struct packed {
        logic load;
        logic square;
        logic update;
        logic div_init;
        logic div_step;
        logic root_init;
        logic root_step;
        logic judge;
        logic emit;
    } fer_cmd_t;

    typedef struct packed {
        logic step_last;
        logic out_free;
    } fer_status_t;

endpackage

@@ design/following_error_rms_monitor_top.sv @@
// Top level of the following-error RMS monitor: joins controller and datapath.
// Depends on fer_pkg, fer_ctrl and fer_dp.
//
// Channel   Direction  Handshake              Word
// s_        in         s_tvalid / s_tready    error sample
// m_        out        m_tvalid / m_tready    rms_level, peak_level, warn_flag
// cfg_      in         cfg_valid / cfg_ready  base_level
//
// A result reaches m_tvalid after its sample passes the square, ring update, the
// one-bit-per-cycle divider, the square root and the judge step.
// Samples are taken one at a time; the next is accepted in the cycle after a result is
// registered, even while that result still waits on m_tready. A result that is still
// waiting holds the next one, and s_tready.
// Reset is synchronous and active low; the ring needs no clearing pass.
module following_error_rms_monitor_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // [23:0] error sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fer_pkg::MDATA_W-1:0]     m_tdata,   // [23:0] rms_level,
                                                        // [47:24] peak_level,
                                                        // [48] warn_flag
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fer_pkg::BASE_W-1:0]      cfg_data    // [22:0] base_level
);
    import fer_pkg::*;

    fer_cmd_t    cmd;
    fer_status_t status;

    assign cfg_ready = 1'b1;

    fer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fer_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .sample    ($signed(s_tdata)),
        .cfg_write (cfg_valid),
        .cfg_value (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

@@ design/fer_ctrl.sv @@
// Sequencing controller of the following-error RMS monitor.
// Steps one sample through square, ring update, divide, root and warning stages.
// Depends on fer_pkg.
module fer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fer_pkg::fer_status_t status,
    output fer_pkg::fer_cmd_t    cmd
);
    import fer_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SQUARE    = 9'b000000010,
        ST_UPDATE    = 9'b000000100,
        ST_DIV_INIT  = 9'b000001000,
        ST_DIVIDE    = 9'b000010000,
        ST_ROOT_INIT = 9'b000100000,
        ST_ROOT      = 9'b001000000,
        ST_JUDGE     = 9'b010000000,
        ST_EMIT      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: begin
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                cmd.judge  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/fer_dp.sv @@
// Datapath of the following-error RMS monitor.
// Holds the square ring, running sum, bit-serial divider and square root,
// peak and warning counter, baseline register and result register. Depends on fer_pkg.
module fer_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  fer_pkg::fer_cmd_t                cmd,
    output fer_pkg::fer_status_t             status,
    input  logic signed [fer_pkg::SAMPLE_W-1:0] sample,
    input  logic                             cfg_write,
    input  logic [fer_pkg::BASE_W-1:0]       cfg_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fer_pkg::MDATA_W-1:0]      out_data
);
    import fer_pkg::*;

    logic [SQ_W-1:0]     ring_mem [WINDOW];
    logic [SQ_W-1:0]     ring_rd_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                filled_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SAMPLE_W-1:0] peak_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [CNT_W-1:0]    drem_reg;
    logic [SQ_W-1:0]     quot_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rrem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [WCNT_W-1:0]   wcnt_reg;
    logic [WCNT_W-1:0]   wcnt_next;
    logic [SAMPLE_W-1:0] rms_reg;
    logic                out_valid_reg;
    logic [MDATA_W-1:0]  out_data_reg;

    logic [2*SAMPLE_W-1:0] sq_full;
    logic [CNT_W:0]      dtrial;
    logic                dfit;
    logic [REM_W-1:0]    rshift;
    logic [REM_W-1:0]    rtrial;
    logic                rfit;
    logic [SAMPLE_W:0]   rms_x2;
    logic [SAMPLE_W:0]   base_x3;
    logic [CNT_W-1:0]    count_now;

    assign sq_full   = mag_reg * mag_reg;
    assign dtrial    = {drem_reg, quot_reg[SQ_W-1]};
    assign dfit      = dtrial >= {1'b0, divisor_reg};
    assign rshift    = {rrem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign rtrial    = {1'b0, root_reg, 2'b01};
    assign rfit      = rshift >= rtrial;
    assign rms_x2    = {root_reg, 1'b0};
    assign base_x3   = {2'b00, base_reg} + {1'b0, base_reg, 1'b0};
    assign count_now = filled_reg ? COUNT_FULL : CNT_W'(pos_reg);

    always_comb begin
        wcnt_next = '0;
        if (base_reg >= BASE_MIN && rms_x2 > base_x3) begin
            wcnt_next = (wcnt_reg < COUNT_MAX) ? wcnt_reg + 1'b1 : wcnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[pos_reg] <= sq_reg;
        end
        ring_rd_reg <= ring_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
        end
        if (cmd.square) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (cmd.div_init) begin
            divisor_reg <= count_now;
            drem_reg    <= sum_reg[SUM_W-1:SQ_W];
            quot_reg    <= sum_reg[SQ_W-1:0];
            step_reg    <= DIV_STEPS;
        end
        if (cmd.div_step) begin
            drem_reg <= dfit ? CNT_W'(dtrial - {1'b0, divisor_reg}) : CNT_W'(dtrial);
            quot_reg <= {quot_reg[SQ_W-2:0], dfit};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.root_init) begin
            rad_reg  <= RAD_W'(quot_reg);
            rrem_reg <= '0;
            root_reg <= '0;
            step_reg <= ROOT_STEPS;
        end
        if (cmd.root_step) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rrem_reg <= rfit ? rshift - rtrial : rshift;
            root_reg <= {root_reg[ROOT_W-2:0], rfit};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.emit) begin
            out_data_reg <= MDATA_W'({wcnt_reg > WARN_LIM, peak_reg, rms_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            base_reg      <= '0;
            wcnt_reg      <= '0;
            rms_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                base_reg <= cfg_value;
            end
            if (cmd.square) begin
                if (mag_reg > peak_reg) begin
                    peak_reg <= mag_reg;
                end
                if (filled_reg) begin
                    sum_reg <= sum_reg - SUM_W'(ring_rd_reg);
                end
            end
            if (cmd.update) begin
                sum_reg <= sum_reg + SUM_W'(sq_reg);
                if (pos_reg == POS_LAST) begin
                    pos_reg    <= '0;
                    filled_reg <= 1'b1;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (cmd.judge) begin
                rms_reg  <= SAMPLE_W'(root_reg);
                wcnt_reg <= wcnt_next;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.step_last = (step_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

@@ dv/following_error_rms_monitor_top_tb.sv @@
// Self-checking testbench for following_error_rms_monitor_top: drives samples, baseline
// writes and random back-pressure, and checks each result against a windowed RMS predictor.
// Depends on fer_pkg and the following_error_rms_monitor_top RTL.
module following_error_rms_monitor_top_tb;
    import fer_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned REPORT_MAX   = 200;

    typedef struct packed {
        logic [23:0] rms;
        logic [23:0] peak;
        logic        warn;
    } rms_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MDATA_W-1:0]  m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BASE_W-1:0]   cfg_data = '0;

    // Predictor state.
    logic [SQ_W-1:0]     square_hist [0:WINDOW-1];
    int unsigned         hist_wr = 0;
    bit                  hist_full = 1'b0;
    logic [63:0]         square_total = '0;
    logic [23:0]         peak_seen = '0;
    logic [31:0]         rms_now = '0;
    logic [WCNT_W-1:0]   over_run = '0;
    logic [BASE_W-1:0]   baseline = '0;

    rms_result_t         rms_expected [$];
    int unsigned         errors = 0;
    int unsigned         reports = 0;
    int unsigned         clk_ticks = 0;

    bit                  idle_en = 1'b1;
    int unsigned         hold_req = 0;
    int unsigned         ready_wait = 0;

    following_error_rms_monitor_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [23:0] error sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [23:0] rms_level, [47:24] peak_level,
                                 // [48] warn_flag
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)    // [22:0] base_level
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        clk_ticks++;
        if (clk_ticks == LIMIT_CYCLES) begin
            $display("following_error_rms_monitor_top regression: fail");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input int unsigned long_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < long_pct)
            return $urandom_range(20, 150);
        else if (r < long_pct + 15)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    task automatic predict_rms(input logic [23:0] raw);
        logic [23:0]  mag;
        logic [63:0]  sq;
        logic [63:0]  held;
        rms_result_t  res;
        mag = raw[23] ? (24'd0 - raw) : raw;
        sq = 64'(mag) * 64'(mag);
        if (mag > peak_seen)
            peak_seen = mag;
        if (hist_full)
            square_total -= 64'(square_hist[hist_wr]);
        square_hist[hist_wr] = sq[SQ_W-1:0];
        square_total += sq;
        if (hist_wr == WINDOW - 1) begin
            hist_wr = 0;
            hist_full = 1'b1;
        end else begin
            hist_wr++;
        end
        held = hist_full ? 64'(WINDOW) : 64'(hist_wr);
        rms_now = floor_root(square_total / held);
        if (baseline >= BASE_MIN && (64'(rms_now) << 1) > 64'(baseline) * 64'd3) begin
            if (over_run != COUNT_MAX)
                over_run++;
        end else begin
            over_run = '0;
        end
        res.rms = rms_now[23:0];
        res.peak = peak_seen;
        res.warn = (over_run > WARN_LIM);
        rms_expected.push_back(res);
    endtask

    // Result checking and prediction, all evaluated on pre-edge values.
    always @(posedge aclk) begin
        rms_result_t exp_res;
        rms_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rms = m_tdata[23:0];
                got.peak = m_tdata[47:24];
                got.warn = m_tdata[48];
                if (rms_expected.size() == 0) begin
                    errors++;
                    if (reports++ < REPORT_MAX)
                        $display("%0t: expected no word, actual rms %0d peak %0d warning %0b",
                                 $time, got.rms, got.peak, got.warn);
                end else begin
                    exp_res = rms_expected.pop_front();
                    if (got.rms !== exp_res.rms) begin
                        errors++;
                        if (reports++ < REPORT_MAX)
                            $display("%0t: rms level expected %0d actual %0d",
                                     $time, exp_res.rms, got.rms);
                    end
                    if (got.peak !== exp_res.peak) begin
                        errors++;
                        if (reports++ < REPORT_MAX)
                            $display("%0t: peak level expected %0d actual %0d",
                                     $time, exp_res.peak, got.peak);
                    end
                    if (got.warn !== exp_res.warn) begin
                        errors++;
                        if (reports++ < REPORT_MAX)
                            $display("%0t: warning flag expected %0b actual %0b",
                                     $time, exp_res.warn, got.warn);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                baseline = cfg_data;
            if (s_tvalid && s_tready)
                predict_rms(s_tdata);
        end
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req != 0) begin
                ready_wait = hold_req;
                hold_req = 0;
            end else if (ready_wait == 0 && idle_en) begin
                ready_wait = pick_gap(1);
            end
            if (ready_wait != 0) begin
                ready_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Leaves s_tvalid high after the handshake so back-to-back words need no toggle.
    task automatic send_sample(input logic [23:0] sample);
        int unsigned gap;
        gap = idle_en ? pick_gap(2) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (rms_expected.size() != 0);
    endtask

    task automatic write_baseline(input logic [BASE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] random_sample();
        int unsigned pick;
        logic [23:0] mag;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return 24'($urandom());
            4, 5: mag = 24'($urandom_range(0, 255));
            6, 7: mag = 24'($urandom_range(0, 4095));
            8: mag = 24'($urandom_range(0, 1 << 20));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 24'h7fffff;
                    1: return 24'h800000;
                    2: return 24'h800001;
                    3: return 24'h000000;
                    4: return 24'h000001;
                    default: return 24'hffffff;
                endcase
            end
        endcase
        return $urandom_range(0, 1) ? (24'd0 - mag) : mag;
    endfunction

    task automatic test_sample_extremes();
        write_baseline('0);
        send_sample(24'h000000);
        send_sample(24'h000001);
        send_sample(24'hffffff);
        send_sample(24'h000002);
        send_sample(24'h0000ff);
        send_sample(24'hffff00);
        send_sample(24'h555555);
        send_sample(24'haaaaaa);
        send_sample(24'h7fffff);
        send_sample(24'h800001);
        send_sample(24'h800000);
        send_sample(24'h000000);
        wait_all_results();
    endtask

    task automatic test_baseline_threshold();
        write_baseline(BASE_W'(6));
        repeat (5) send_sample(24'hff0000);
        wait_all_results();
        write_baseline(BASE_MIN);
        repeat (5) send_sample(24'h010000);
        wait_all_results();
    endtask

    task automatic test_window_random();
        logic [BASE_W-1:0] settings [5];
        settings[0] = BASE_W'($urandom());
        settings[1] = {BASE_W{1'b1}};
        settings[2] = '0;
        settings[3] = BASE_MIN;
        settings[4] = BASE_W'($urandom_range(7, 3000));
        foreach (settings[i]) begin
            write_baseline(settings[i]);
            repeat (300) send_sample(random_sample());
            wait_all_results();
        end
    endtask

    task automatic test_output_stall();
        hold_req = 600;
        idle_en = 1'b0;
        repeat (12) send_sample(random_sample());
        idle_en = 1'b1;
        wait_all_results();
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        repeat (100) send_sample(random_sample());
        wait_all_results();
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sample_extremes();
        test_baseline_threshold();
        test_window_random();
        test_output_stall();
        test_back_to_back();
        repeat (200) @(posedge aclk);
        if (errors == 0 && rms_expected.size() == 0)
            $display("following_error_rms_monitor_top regression: pass");
        else
            $display("following_error_rms_monitor_top regression: fail");
        $finish;
    end

endmodule
